// ===== src/mlp_pkg.sv =====
// shared types, constants and fixed-point helpers for the mlp sigmoid core
// no dependencies
package mlp_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HIDDEN = 4;
  localparam int DATA_BITS  = 16;
  localparam int FRAC_BITS  = DATA_BITS - 5;
  localparam int LAYERS     = MAX_HIDDEN + 1;
  localparam int ACC_BITS   = 2 * DATA_BITS + $clog2(MAX_WIDTH) + 2;

  localparam int W_DEPTH  = LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int B_DEPTH  = LAYERS * MAX_WIDTH;
  localparam int W_AW     = $clog2(W_DEPTH);
  localparam int B_AW     = $clog2(B_DEPTH);
  localparam int IDX_BITS = $clog2(MAX_WIDTH);

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [1:0] REG_INPUT_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_WIDTH = 2'd1;
  localparam logic [1:0] REG_OUTPUT_WIDTH = 2'd2;
  localparam logic [1:0] REG_HIDDEN_COUNT = 2'd3;

  localparam logic [16:0] SIG_ONE  = 17'd1 << FRAC_BITS;
  localparam logic [16:0] SIG_SAT  = 17'd5 * SIG_ONE;
  localparam logic [16:0] SIG_MID  = (17'd19 * SIG_ONE) >> 3;
  localparam logic [16:0] SIG_OFS2 = (17'd27 * SIG_ONE) >> 5;
  localparam logic [16:0] SIG_OFS1 = (17'd5 * SIG_ONE) >> 3;
  localparam logic [16:0] SIG_OFS0 = SIG_ONE >> 1;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

  // round half up to FRAC_BITS, then clamp to the data range
  function automatic logic signed [DATA_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] t;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    t  = (acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    hi = (ACC_BITS'(1) <<< (DATA_BITS - 1)) - ACC_BITS'(1);
    lo = -hi - ACC_BITS'(1);
    if (t > hi) return hi[DATA_BITS-1:0];
    else if (t < lo) return lo[DATA_BITS-1:0];
    else return t[DATA_BITS-1:0];
  endfunction

  // piecewise linear sigmoid, result 0..one
  function automatic logic [11:0] sigmoid_fx(input logic signed [DATA_BITS-1:0] x);
    logic [16:0] a;
    logic [16:0] y;
    a = x[DATA_BITS-1] ? 17'(-{x[DATA_BITS-1], x}) : 17'({1'b0, x});
    if (a >= SIG_SAT) y = SIG_ONE;
    else if (a >= SIG_MID) y = (a >> 5) + SIG_OFS2;
    else if (a >= SIG_ONE) y = (a >> 3) + SIG_OFS1;
    else y = (a >> 2) + SIG_OFS0;
    if (x[DATA_BITS-1]) y = SIG_ONE - y;
    return y[11:0];
  endfunction

endpackage

// ===== src/mlp_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/mlp_mac.sv =====
// shared multiply-accumulate unit with rounding, clamp and sigmoid on the sum
// depends on mlp_pkg
module mlp_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  mlp_pkg::mac_ctl_t       ctl,
  input  logic [15:0]             weight,
  input  logic [15:0]             act,
  input  logic [15:0]             bias,
  output logic [11:0]             result
);
  import mlp_pkg::*;

  mac_ctl_t                    ctl_d;
  logic                        prod_valid;
  logic signed [31:0]          prod;
  logic signed [ACC_BITS-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d      <= '0;
      prod_valid <= 1'b0;
    end else begin
      ctl_d      <= ctl;
      prod_valid <= ctl_d.valid;
    end
  end

  // ram data lines up with ctl_d
  always_ff @(posedge clk) begin
    prod <= $signed(weight) * $signed(act);
    if (ctl_d.valid && ctl_d.first) begin
      acc <= ACC_BITS'($signed(bias)) <<< FRAC_BITS;
    end else if (prod_valid) begin
      acc <= acc + ACC_BITS'(prod);
    end
  end

  assign result = sigmoid_fx(round_sat(acc));
endmodule

// ===== src/mlp_sigmoid_forward_pass_core.sv =====
// top level of the mlp sigmoid inference core: sequencer, parameter and
// activation memories, apb registers; depends on mlp_pkg, mlp_ram, mlp_mac
//
// usage: load items (mode weight or bias) write one parameter each. sample
// items bring input elements in order; the one with last set starts a pass.
// start is taken when busy is low; busy stays high for the whole pass. each
// output neuron gives one result on done for one cycle, with activation,
// index, last_res on the final one and size_error.
// a pass first zero fills missing inputs, then computes every neuron of
// every layer in turn, all through the single multiply-accumulate unit.
// results leave one at a time as the output layer is computed. the
// receiver cannot stall and need not.
// reset clears the sequencer, element count and registers (64, 64, 64, 1);
// weights, biases and activations stay undefined until written.
// registers are written and read over apb at byte addresses 0, 4, 8, 12.
module mlp_sigmoid_forward_pass_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [2:0]  layer,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic signed [15:0] value,
  input  logic        last,
  output logic        done,
  output logic [11:0] activation,
  output logic [5:0]  index,
  output logic        last_res,
  output logic        size_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_ISSUE = 6'b000100,
    S_DRAIN = 6'b001000,
    S_FIN   = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t state;
  logic [6:0] input_width, hidden_width, output_width;
  logic [2:0] hidden_count;
  logic [6:0] iw, hw, ow;
  logic [2:0] hc;
  logic [6:0] element_count, count_inc;
  logic [6:0] fill_idx;
  logic [2:0] lyr;
  logic [5:0] j, k;
  logic [6:0] prev;
  logic [6:0] n_cur;
  logic [1:0] drain;
  logic       err;
  logic [11:0] res;
  logic       accept;

  logic                we_w, we_b;
  logic [15:0]         w_rd, b_rd, a_rd, b2_rd;
  logic                we_a, we_p;
  logic [IDX_BITS-1:0] wa_a, wa_p;
  logic [15:0]         wd_a, wd_p;
  mac_ctl_t            mac_ctl;
  logic [11:0]         mac_res;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign iw = (input_width == 7'd0) ? 7'd1 :
              (input_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : input_width;
  assign hw = (hidden_width == 7'd0) ? 7'd1 :
              (hidden_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : hidden_width;
  assign ow = (output_width == 7'd0) ? 7'd1 :
              (output_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : output_width;
  assign hc = (hidden_count > 3'(MAX_HIDDEN)) ? 3'(MAX_HIDDEN) : hidden_count;
  assign n_cur = (lyr == hc) ? ow : hw;
  assign count_inc = (element_count == 7'd127) ? 7'd127 : element_count + 7'd1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_width  <= 7'd64;
      hidden_width <= 7'd64;
      output_width <= 7'd64;
      hidden_count <= 3'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_INPUT_WIDTH:  input_width  <= pwdata[6:0];
        REG_HIDDEN_WIDTH: hidden_width <= pwdata[6:0];
        REG_OUTPUT_WIDTH: output_width <= pwdata[6:0];
        REG_HIDDEN_COUNT: hidden_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INPUT_WIDTH:  prdata = {25'd0, input_width};
      REG_HIDDEN_WIDTH: prdata = {25'd0, hidden_width};
      REG_OUTPUT_WIDTH: prdata = {25'd0, output_width};
      REG_HIDDEN_COUNT: prdata = {29'd0, hidden_count};
      default:          prdata = '0;
    endcase
  end

  assign we_w = accept && (mode == MODE_WEIGHT) && (layer <= 3'(MAX_HIDDEN));
  assign we_b = accept && (mode == MODE_BIAS) && (layer <= 3'(MAX_HIDDEN));

  // activation write ports: sample loads and zero fill go to ping, layer
  // outputs go to whichever side is not being read
  always_comb begin
    we_a = 1'b0;
    wa_a = '0;
    wd_a = '0;
    we_p = 1'b0;
    wa_p = j;
    wd_p = {4'd0, res};
    if (accept && mode == MODE_SAMPLE && element_count < iw) begin
      we_a = 1'b1;
      wa_a = element_count[5:0];
      wd_a = value;
    end else if (state == S_FILL && fill_idx < iw) begin
      we_a = 1'b1;
      wa_a = fill_idx[5:0];
    end else if (state == S_WRITE && lyr[0]) begin
      we_a = 1'b1;
      wa_a = j;
      wd_a = {4'd0, res};
    end
    we_p = (state == S_WRITE) && !lyr[0];
  end

  assign mac_ctl.valid = (state == S_ISSUE);
  assign mac_ctl.first = (k == 6'd0);

  mlp_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wmem (
    .clk(clk), .we(we_w), .waddr({layer, row, col}), .wdata(value),
    .raddr({lyr, j, k}), .rdata(w_rd)
  );

  mlp_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bmem (
    .clk(clk), .we(we_b), .waddr({layer, row}), .wdata(value),
    .raddr({lyr, j}), .rdata(b_rd)
  );

  mlp_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_ping (
    .clk(clk), .we(we_a), .waddr(wa_a), .wdata(wd_a),
    .raddr(k), .rdata(a_rd)
  );

  mlp_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_pong (
    .clk(clk), .we(we_p), .waddr(wa_p), .wdata(wd_p),
    .raddr(k), .rdata(b2_rd)
  );

  mlp_mac u_mac (
    .clk(clk), .rst(rst), .ctl(mac_ctl),
    .weight(w_rd), .act(lyr[0] ? b2_rd : a_rd), .bias(b_rd),
    .result(mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && mode == MODE_SAMPLE) begin
            if (last) begin
              element_count <= '0;
              state         <= S_FILL;
            end else begin
              element_count <= count_inc;
            end
          end
        end
        S_FILL: begin
          if (fill_idx >= iw) state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (7'(k) == prev - 7'd1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain == 2'd2) state <= S_FIN;
        end
        S_FIN: state <= S_WRITE;
        S_WRITE: begin
          done <= (lyr == hc);
          if (7'(j) == n_cur - 7'd1 && lyr == hc) state <= S_IDLE;
          else state <= S_ISSUE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // sequencer counters and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && mode == MODE_SAMPLE && last) begin
          err      <= (count_inc != iw);
          fill_idx <= count_inc;
        end
        lyr  <= '0;
        j    <= '0;
        k    <= '0;
        prev <= iw;
      end
      S_FILL: begin
        if (fill_idx < iw) fill_idx <= fill_idx + 7'd1;
        prev <= iw;
      end
      S_ISSUE: begin
        k     <= k + 6'd1;
        drain <= '0;
      end
      S_DRAIN: drain <= drain + 2'd1;
      S_FIN:   res <= mac_res;
      S_WRITE: begin
        k          <= '0;
        activation <= res;
        index      <= j;
        last_res   <= (7'(j) == n_cur - 7'd1);
        size_error <= err;
        if (7'(j) == n_cur - 7'd1) begin
          j    <= '0;
          lyr  <= lyr + 3'd1;
          prev <= n_cur;
        end else begin
          j <= j + 6'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/mlp_chk.sv =====
// port-level checker for the mlp sigmoid core, bound to the top level
// depends on mlp_sigmoid_forward_pass_core
module mlp_chk (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic last_res
);
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last_res |-> busy) else $error("result mid-run while idle");

  a_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("results back to back");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    done && last_res |-> !busy) else $error("still busy after final result");

  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !done) else $error("not idle after reset");
endmodule

bind mlp_sigmoid_forward_pass_core mlp_chk u_chk (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .last_res(last_res)
);

// ===== tb/sv/mlp_sigmoid_forward_pass_core_tb.sv =====
// testbench for mlp_sigmoid_forward_pass_core: drives load and sample items and
// apb register writes, predicts every output activation and checks it on done
// depends on mlp_pkg and the core rtl
`timescale 1ns / 100ps

module mlp_sigmoid_forward_pass_core_tb;
  import mlp_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  // widest layer any pass here uses, so the parameter fill stays short
  localparam int FILL_WIDTH = 2;

  typedef struct {
    logic [11:0] act;
    logic [5:0]  idx;
    logic        lst;
    logic        serr;
  } neuron_out_t;

  class mlp_scoreboard;
    int          weights [LAYERS][MAX_WIDTH][MAX_WIDTH];
    int          biases  [LAYERS][MAX_WIDTH];
    longint      in_vec  [MAX_WIDTH];
    int          elem_cnt;
    int          reg_iw, reg_hw, reg_ow, reg_hc;
    neuron_out_t pending[$];
    int          errors;
    int          passes;
    int          outputs;

    function new();
      elem_cnt = 0;
      reg_iw = 64; reg_hw = 64; reg_ow = 64; reg_hc = 1;
      errors = 0; passes = 0; outputs = 0;
    endfunction

    function void set_reg(logic [1:0] which, int val);
      case (which)
        REG_INPUT_WIDTH:  reg_iw = val & 127;
        REG_HIDDEN_WIDTH: reg_hw = val & 127;
        REG_OUTPUT_WIDTH: reg_ow = val & 127;
        default:          reg_hc = val & 7;
      endcase
    endfunction

    function int clip_width(int w);
      if (w == 0) return 1;
      return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint squash(longint x);
      longint one, a, y;
      one = 1 << FRAC_BITS;
      a = (x < 0) ? -x : x;
      if (a >= 5 * one) y = one;
      else if (a >= ((19 * one) >>> 3)) y = (a >>> 5) + ((27 * one) >>> 5);
      else if (a >= one) y = (a >>> 3) + ((5 * one) >>> 3);
      else y = (a >>> 2) + (one >>> 1);
      return (x < 0) ? one - y : y;
    endfunction

    // record an accepted item; a sample item with last runs the forward pass
    function void note_item(logic [1:0] md, logic [2:0] ly, logic [5:0] r,
                            logic [5:0] c, logic signed [15:0] v, logic lst);
      int iw, hw, ow, hc, prev, n;
      bit serr;
      longint cur[MAX_WIDTH];
      longint nxt[MAX_WIDTH];
      longint acc;
      neuron_out_t o;
      if (md == MODE_WEIGHT || md == MODE_BIAS) begin
        if (ly > MAX_HIDDEN) return;
        if (md == MODE_WEIGHT) weights[ly][r][c] = v;
        else biases[ly][r] = v;
        return;
      end
      if (md != MODE_SAMPLE) return;
      iw = clip_width(reg_iw);
      if (elem_cnt < iw) in_vec[elem_cnt] = clamp16(v);
      if (elem_cnt < 127) elem_cnt++;
      if (!lst) return;
      serr = (elem_cnt != iw);
      for (int i = elem_cnt; i < iw; i++) in_vec[i] = 0;
      elem_cnt = 0;
      hw = clip_width(reg_hw);
      ow = clip_width(reg_ow);
      hc = (reg_hc > MAX_HIDDEN) ? MAX_HIDDEN : reg_hc;
      cur = in_vec;
      prev = iw;
      for (int l = 0; l <= hc; l++) begin
        n = (l == hc) ? ow : hw;
        for (int j = 0; j < n; j++) begin
          acc = longint'(biases[l][j]) <<< FRAC_BITS;
          for (int k = 0; k < prev; k++) acc += longint'(weights[l][j][k]) * cur[k];
          acc = (acc + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
          nxt[j] = squash(clamp16(acc));
        end
        cur = nxt;
        prev = n;
      end
      for (int j = 0; j < ow; j++) begin
        o.act = cur[j][11:0];
        o.idx = j[5:0];
        o.lst = (j + 1 == ow);
        o.serr = serr;
        pending.insert(pending.size(), o);
      end
      passes++;
    endfunction

    function void check_output(logic [11:0] act, logic [5:0] idx, logic lst, logic serr);
      neuron_out_t e;
      outputs++;
      if (pending.size() == 0) begin
        $error("unexpected result: activation %0d index %0d", act, idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act !== e.act) begin
        $error("activation: expected %0d, got %0d", e.act, act); errors++;
      end
      if (idx !== e.idx) begin
        $error("index: expected %0d, got %0d", e.idx, idx); errors++;
      end
      if (lst !== e.lst) begin
        $error("last_res: expected %0d, got %0d", e.lst, lst); errors++;
      end
      if (serr !== e.serr) begin
        $error("size_error: expected %0d, got %0d", e.serr, serr); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, last, done, last_res, size_error;
  logic psel, penable, pwrite, pready;
  logic [1:0] mode;
  logic [2:0] layer;
  logic [5:0] row, col, index;
  logic signed [15:0] value;
  logic [11:0] activation;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  mlp_scoreboard sb;
  bit idling;
  int items_sent;

  mlp_sigmoid_forward_pass_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .layer(layer), .row(row), .col(col), .value(value), .last(last),
    .done(done), .activation(activation), .index(index), .last_res(last_res),
    .size_error(size_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_output(activation, index, last_res, size_error);
  end

  // one item: hold start until it is taken
  task automatic send_item(logic [1:0] md, logic [2:0] ly, logic [5:0] r,
                           logic [5:0] c, logic signed [15:0] v, logic lst);
    bit taken;
    if (idling && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    mode = md; layer = ly; row = r; col = c; value = v; last = lst;
    start = 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
    end while (!taken);
    sb.note_item(md, ly, r, c, v, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] which, int val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {which, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(which, val);
  endtask

  task automatic set_shape(int iw, int hw, int ow, int hc);
    wait_idle();
    write_reg(REG_INPUT_WIDTH, iw);
    write_reg(REG_HIDDEN_WIDTH, hw);
    write_reg(REG_OUTPUT_WIDTH, ow);
    write_reg(REG_HIDDEN_COUNT, hc);
  endtask

  function automatic logic signed [15:0] mild_value();
    return 16'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  // n sample elements of random content, last on the final one
  task automatic send_vector(int n);
    logic signed [15:0] v;
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : mild_value();
      send_item(MODE_SAMPLE, 3'($urandom), 6'($urandom), 6'($urandom), v, i == n - 1);
    end
  endtask

  task automatic send_random_load();
    logic [1:0] md;
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0:       md = MODE_IGNORED;
      1, 2, 3: md = MODE_BIAS;
      default: md = MODE_WEIGHT;
    endcase
    v = ($urandom_range(0, 2) == 0) ? 16'($urandom) : mild_value();
    send_item(md, 3'($urandom), 6'($urandom), 6'($urandom), v, 1'($urandom));
  endtask

  initial begin
    int iw, n;
    sb = new();
    rst = 1'b1; start = 1'b0; idling = 1'b0; items_sent = 0;
    mode = MODE_WEIGHT; layer = '0; row = '0; col = '0; value = '0; last = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // fill every parameter that the shapes below can reach
    for (int l = 0; l < LAYERS; l++)
      for (int r = 0; r < FILL_WIDTH; r++) begin
        send_item(MODE_BIAS, 3'(l), 6'(r), 6'($urandom), mild_value(), 1'b0);
        for (int c = 0; c < FILL_WIDTH; c++)
          send_item(MODE_WEIGHT, 3'(l), 6'(r), 6'(c), 16'($signed(mild_value()) >>> 3),
                    1'b0);
      end
    idling = 1'b1;

    // directed: field extremes, ignored writes, short and long vectors
    set_shape(FILL_WIDTH, FILL_WIDTH, FILL_WIDTH, 1);
    send_item(MODE_WEIGHT, 3'd0, 6'd0, 6'd0, 16'sh7fff, 1'b1);
    send_item(MODE_WEIGHT, 3'd0, 6'd1, 6'd2, -16'sd32768, 1'b0);
    send_item(MODE_BIAS, 3'd1, 6'd1, 6'd63, 16'sh7fff, 1'b1);
    send_item(MODE_WEIGHT, 3'd4, 6'd63, 6'd63, -16'sd1, 1'b0);
    send_item(MODE_WEIGHT, 3'd7, 6'd0, 6'd0, 16'sd5, 1'b0);
    send_item(MODE_BIAS, 3'd5, 6'd63, 6'd0, -16'sd7, 1'b1);
    send_item(MODE_IGNORED, 3'd2, 6'd3, 6'd4, 16'sd100, 1'b1);
    send_item(MODE_SAMPLE, 3'd7, 6'd63, 6'd63, 16'sh7fff, 1'b0);
    send_item(MODE_SAMPLE, 3'd0, 6'd0, 6'd0, -16'sd32768, 1'b0);
    send_item(MODE_SAMPLE, 3'd0, 6'd0, 6'd0, 16'sd0, 1'b1);
    send_item(MODE_SAMPLE, 3'd0, 6'd0, 6'd0, 16'sd2048, 1'b1);
    send_vector(5);
    send_vector(3);

    // register extremes: zero widths act as one, a large hidden count is capped
    set_shape(0, 0, 0, 0);
    send_vector(1);
    send_vector(2);
    set_shape(FILL_WIDTH, FILL_WIDTH, FILL_WIDTH, 7);
    send_vector(FILL_WIDTH);

    // random part: small shapes, mostly well formed vectors among loads
    while (items_sent < 100) begin
      if (items_sent > 85) idling = 1'b0;
      set_shape($urandom_range(1, FILL_WIDTH), $urandom_range(1, FILL_WIDTH),
                $urandom_range(1, FILL_WIDTH), $urandom_range(0, 4));
      iw = sb.reg_iw;
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 4)) send_random_load();
        case ($urandom_range(0, 19))
          0:       n = iw + 6;
          1, 2, 3: n = $urandom_range(1, iw + 3);
          default: n = iw;
        endcase
        send_vector(n);
      end
    end

    wait_idle();
    repeat (200) @(negedge clk);
    $display("covered %0d items, %0d passes, %0d results",
             items_sent, sb.passes, sb.outputs);
    $display("shapes from all-zero registers to a capped hidden count, short and long vectors");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== mlp_sigmoid_forward_pass_core.f =====
src/mlp_pkg.sv
src/mlp_ram.sv
src/mlp_mac.sv
src/mlp_sigmoid_forward_pass_core.sv
src/mlp_chk.sv
tb/sv/mlp_sigmoid_forward_pass_core_tb.sv
